[rtl/dtr_pkg.sv]
// types, constants and helpers shared by the divider and reloading timer
`default_nettype none

package dtr_pkg;

	// seconds tick period in machine cycles and its counter width
	localparam int unsigned RTC_PERIOD = 4194304;
	localparam int unsigned RTC_W      = $clog2(RTC_PERIOD);
	localparam logic [RTC_W:0] RTC_PERIOD_C = (RTC_W + 1)'(RTC_PERIOD);

	// largest step taken in one beat
	localparam logic [7:0] MAX_STEP_CYCLES = 8'd255;

	// timer residual width, wide enough for a full long period plus one step
	localparam int unsigned TRES_W = 11;

	// divider step intervals
	localparam logic [8:0] DIV_STEP_NORMAL = 9'd256;
	localparam logic [8:0] DIV_STEP_DOUBLE = 9'd128;

	// configuration register indexes
	localparam logic [1:0] CFG_TIMER_MODE   = 2'd0;
	localparam logic [1:0] CFG_RELOAD_VALUE = 2'd1;
	localparam logic [1:0] CFG_DOUBLE_SPEED = 2'd2;

	// timer control bits
	localparam int unsigned TCTRL_ENABLE_BIT = 2;

	// controller states
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic more;
	} sts_t;

	// timer period for a selection, halved at double speed
	function automatic logic [TRES_W-1:0] timer_period(input logic [1:0] sel, input logic ds);
		logic [TRES_W-1:0] p;
		case (sel)
			2'd0:    p = TRES_W'(1024);
			2'd1:    p = TRES_W'(16);
			2'd2:    p = TRES_W'(64);
			default: p = TRES_W'(256);
		endcase
		timer_period = ds ? (p >> 1) : p;
	endfunction

endpackage

`default_nettype wire

[rtl/dtr_in_if.sv]
// input channel: elapsed machine cycles
`default_nettype none

interface dtr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] elapsed_cycles;

	modport source (output valid, output elapsed_cycles, input ready);
	modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

`default_nettype wire

[rtl/dtr_out_if.sv]
// output channel: divider, timer and flags
`default_nettype none

interface dtr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] divider_out;
	logic [7:0] timer_out;
	logic       timer_irq;
	logic       second_tick;

	modport source (output valid, output divider_out, output timer_out,
		output timer_irq, output second_tick, input ready);
	modport sink   (input valid, input divider_out, input timer_out,
		input timer_irq, input second_tick, output ready);
endinterface

`default_nettype wire

[rtl/dtr_cfg_if.sv]
// configuration write channel
`default_nettype none

interface dtr_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/divider_and_reloading_timer.sv]
// top level of the divider and reloading timer
//
// channel  dir  beat contents
// req      in   elapsed_cycles
// rsp      out  divider_out, timer_out, timer_irq, second_tick
// cfg      in   index, data (0 timer_mode, 1 reload_value, 2 double_speed)
//
// a beat runs in order: accept and update divider and seconds count,
// then the timer increments (one per clock through the shared residual
// subtractor), then load the output register
// a beat holds up to 32 timer increments at the shortest period and up to
// 96 right after a switch from the longest one
// req is ready again once the result is in the output register, even while
// rsp stalls; cfg is always ready
// reset clears all state and configuration at once, no clearing pass; the output register is not reset
`default_nettype none

module divider_and_reloading_timer (
	input wire logic   clk,
	input wire logic   arst_n,
	dtr_in_if.sink     req,
	dtr_out_if.source  rsp,
	dtr_cfg_if.sink    cfg
);

	dtr_pkg::cmd_t cmd;
	dtr_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	// controller
	dtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath
	dtr_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.elapsed_cycles (req.elapsed_cycles),
		.cmd            (cmd),
		.sts            (sts),
		.divider_out    (rsp.divider_out),
		.timer_out      (rsp.timer_out),
		.timer_irq      (rsp.timer_irq),
		.second_tick    (rsp.second_tick)
	);

endmodule

`default_nettype wire

[rtl/dtr_ctrl.sv]
// controller state machine: accept, iterate timer increments, deliver
`default_nettype none

module dtr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output dtr_pkg::cmd_t      cmd,
	input  wire dtr_pkg::sts_t sts
);

	dtr_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			dtr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = dtr_pkg::ST_RUN;
				end
			end
			dtr_pkg::ST_RUN: begin
				if (sts.more) begin
					cmd.step = 1'b1;
				end else if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = dtr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dtr_pkg::ST_IDLE;
			end
		endcase
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/dtr_datapath.sv]
// datapath: config registers, divider, timer, seconds count, output register
`default_nettype none

module dtr_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_write,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [7:0]    cfg_data,
	input  wire logic [7:0]    elapsed_cycles,
	input  wire dtr_pkg::cmd_t cmd,
	output dtr_pkg::sts_t      sts,
	output logic [7:0]         divider_out,
	output logic [7:0]         timer_out,
	output logic               timer_irq,
	output logic               second_tick
);

	localparam int unsigned RW  = dtr_pkg::RTC_W;
	localparam int unsigned TRW = dtr_pkg::TRES_W;

	// configuration
	logic [2:0] timer_mode_q;
	logic [7:0] reload_value_q;
	logic       double_speed_q;

	// state
	logic [7:0]     div_residual_q;
	logic [7:0]     div_value_q;
	logic [TRW-1:0] tim_residual_q;
	logic [7:0]     tim_value_q;
	logic [1:0]     period_select_q;
	logic           period_latched_q;
	logic [RW-1:0]  rtc_count_q;
	logic           irq_q;
	logic           tick_q;

	// combinational
	logic [7:0]     cycles;
	logic [RW:0]    rtc_sum;
	logic [8:0]     div_sum;
	logic [1:0]     div_inc;
	logic [7:0]     div_res_next;
	logic [TRW-1:0] period_now;
	logic           tim_enable;

	// configuration writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_mode_q   <= '0;
			reload_value_q <= '0;
			double_speed_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dtr_pkg::CFG_TIMER_MODE:   timer_mode_q   <= cfg_data[2:0];
				dtr_pkg::CFG_RELOAD_VALUE: reload_value_q <= cfg_data;
				dtr_pkg::CFG_DOUBLE_SPEED: double_speed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// step size, seconds count and divider for the accepted beat
	always_comb begin
		cycles  = (elapsed_cycles > dtr_pkg::MAX_STEP_CYCLES) ?
			dtr_pkg::MAX_STEP_CYCLES : elapsed_cycles;
		rtc_sum = {1'b0, rtc_count_q} + (RW + 1)'(cycles);
		div_sum = {1'b0, div_residual_q} + {1'b0, cycles};
		if (double_speed_q) begin
			div_inc      = div_sum[8:7];
			div_res_next = {1'b0, div_sum[6:0]};
		end else begin
			div_inc      = {1'b0, div_sum[8]};
			div_res_next = div_sum[7:0];
		end
	end

	// timer period and loop status
	assign tim_enable = timer_mode_q[dtr_pkg::TCTRL_ENABLE_BIT];
	assign period_now = dtr_pkg::timer_period(period_select_q, double_speed_q);
	assign sts.more   = tim_enable && (tim_residual_q >= period_now);

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_residual_q   <= '0;
			div_value_q      <= '0;
			tim_residual_q   <= '0;
			tim_value_q      <= '0;
			period_select_q  <= '0;
			period_latched_q <= 1'b0;
			rtc_count_q      <= '0;
			irq_q            <= 1'b0;
			tick_q           <= 1'b0;
		end else if (cmd.load) begin
			irq_q <= 1'b0;
			if (rtc_sum >= dtr_pkg::RTC_PERIOD_C) begin
				rtc_count_q <= RW'(rtc_sum - dtr_pkg::RTC_PERIOD_C);
				tick_q      <= 1'b1;
			end else begin
				rtc_count_q <= RW'(rtc_sum);
				tick_q      <= 1'b0;
			end
			div_residual_q <= div_res_next;
			div_value_q    <= div_value_q + {6'd0, div_inc};
			if (tim_enable) begin
				if (!period_latched_q) begin
					period_select_q  <= timer_mode_q[1:0];
					period_latched_q <= 1'b1;
				end
				tim_residual_q <= tim_residual_q + TRW'(cycles);
			end
		end else if (cmd.step) begin
			// one timer increment per cycle, reload on overflow
			tim_residual_q  <= tim_residual_q - period_now;
			period_select_q <= timer_mode_q[1:0];
			if (tim_value_q == 8'hff) begin
				tim_value_q <= reload_value_q;
				irq_q       <= 1'b1;
			end else begin
				tim_value_q <= tim_value_q + 8'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			divider_out <= div_value_q;
			timer_out   <= tim_value_q;
			timer_irq   <= irq_q;
			second_tick <= tick_q;
		end
	end

endmodule

`default_nettype wire

[bench/divider_and_reloading_timer_tb.sv]
// self-checking testbench for the divider and reloading timer
module divider_and_reloading_timer_tb;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned RANDOM_PHASES = 10;
	localparam int unsigned PHASE_ITEMS   = 110;
	localparam int unsigned LONG_ITEMS    = 100;
	localparam int unsigned SETTLE_CYCLES = 200;
	localparam int unsigned GAP_PERCENT   = 31;
	localparam int unsigned NUM_DIRECTED  = 31;

	// register index beyond the list, the block ignores it
	localparam logic [1:0] CFG_NONE = 2'd3;

	// timer control encodings
	localparam logic [2:0] TMR_ON   = 3'b100;
	localparam logic [2:0] SEL_1024 = 3'd0;
	localparam logic [2:0] SEL_16   = 3'd1;
	localparam logic [2:0] SEL_64   = 3'd2;
	localparam logic [2:0] SEL_256  = 3'd3;

	typedef struct packed {
		logic [7:0] divider;
		logic [7:0] timer;
		logic       irq;
		logic       tick;
	} status_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [1:0] reg_idx;
		logic [7:0] value;
		logic       known;
		status_t    want;
	} stim_row_t;

	localparam status_t ZERO_STATUS = '{8'd0, 8'd0, 1'b0, 1'b0};

	// directed beats: extremes, ignored index, masking, latching, disable, speed changes
	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{ROW_ITEM,  CFG_NONE,                  8'd0,   1'b1, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b1, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd1,   1'b1, '{8'd1, 8'd0, 1'b0, 1'b0}},
		'{ROW_WRITE, CFG_NONE,                  8'hFF,  1'b0, ZERO_STATUS},
		'{ROW_WRITE, dtr_pkg::CFG_RELOAD_VALUE, 8'hFE,  1'b0, ZERO_STATUS},
		'{ROW_WRITE, dtr_pkg::CFG_DOUBLE_SPEED, 8'hFF,  1'b0, ZERO_STATUS},
		// upper bits set to check masking of timer control
		'{ROW_WRITE, dtr_pkg::CFG_TIMER_MODE, 8'hF8 | 8'(TMR_ON | SEL_16), 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		// new selection only after the next increment
		'{ROW_WRITE, dtr_pkg::CFG_TIMER_MODE,   8'(TMR_ON | SEL_1024), 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_WRITE, dtr_pkg::CFG_DOUBLE_SPEED, 8'd0,   1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd200, 1'b0, ZERO_STATUS},
		// timer disabled, divider keeps running
		'{ROW_WRITE, dtr_pkg::CFG_TIMER_MODE,   8'(SEL_256), 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_WRITE, dtr_pkg::CFG_TIMER_MODE,   8'(TMR_ON | SEL_256), 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_WRITE, dtr_pkg::CFG_TIMER_MODE,   8'(TMR_ON | SEL_16), 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd255, 1'b0, ZERO_STATUS},
		'{ROW_WRITE, dtr_pkg::CFG_RELOAD_VALUE, 8'd0,   1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd128, 1'b0, ZERO_STATUS},
		'{ROW_ITEM,  CFG_NONE,                  8'd0,   1'b0, ZERO_STATUS}
	};

	logic clk;
	logic arst_n;

	dtr_in_if  req_ch ();
	dtr_out_if rsp_ch ();
	dtr_cfg_if cfg_ch ();

	divider_and_reloading_timer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow registers and counter state of the timer
	logic [2:0]                 shadow_ctrl;
	logic [7:0]                 shadow_reload;
	logic                       shadow_ds;
	logic [8:0]                 div_res;
	logic [7:0]                 div_val;
	logic [dtr_pkg::TRES_W-1:0] tmr_res;
	logic [7:0]                 tmr_val;
	logic [1:0]                 tmr_sel;
	logic                       sel_held;
	logic [dtr_pkg::RTC_W:0]    rtc_count;

	status_t     pending_status [$];
	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;
	bit          gaps_on     = 1'b1;

	// timer period as a power of two: 1024, 16, 64, 256, halved at double speed
	function automatic logic [dtr_pkg::TRES_W-1:0] period_of(input logic [1:0] sel,
		input logic ds);
		int unsigned shift;
		shift = (sel == 2'd0) ? 10 : (2 * sel + 2);
		return dtr_pkg::TRES_W'(1) << (shift - ds);
	endfunction

	// advance divider, seconds count and timer by one beat of elapsed cycles
	task automatic advance_counters(input logic [7:0] elapsed, output status_t res);
		logic [7:0] n;
		logic [8:0] div_step;
		n = (elapsed > dtr_pkg::MAX_STEP_CYCLES) ? dtr_pkg::MAX_STEP_CYCLES : elapsed;
		res = '0;
		rtc_count = rtc_count + n;
		if (rtc_count >= dtr_pkg::RTC_PERIOD_C) begin
			rtc_count = rtc_count - dtr_pkg::RTC_PERIOD_C;
			res.tick = 1'b1;
		end
		div_step = shadow_ds ? dtr_pkg::DIV_STEP_DOUBLE : dtr_pkg::DIV_STEP_NORMAL;
		div_res = div_res + n;
		while (div_res >= div_step) begin
			div_res = div_res - div_step;
			div_val = div_val + 8'd1;
		end
		if (shadow_ctrl[dtr_pkg::TCTRL_ENABLE_BIT]) begin
			if (!sel_held) begin
				tmr_sel  = shadow_ctrl[1:0];
				sel_held = 1'b1;
			end
			tmr_res = tmr_res + n;
			while (tmr_res >= period_of(tmr_sel, shadow_ds)) begin
				tmr_res = tmr_res - period_of(tmr_sel, shadow_ds);
				tmr_val = tmr_val + 8'd1;
				if (tmr_val == 8'd0) begin
					tmr_val = shadow_reload;
					res.irq = 1'b1;
				end
				// selection is re-read after every increment
				tmr_sel = shadow_ctrl[1:0];
			end
		end
		res.divider = div_val;
		res.timer   = tmr_val;
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// mostly random step sizes with extremes and short steps mixed in
	function automatic logic [7:0] pick_elapsed();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return 8'd0;
			1:       return 8'd255;
			2, 3:    return 8'($urandom_range(1, 16));
			default: return 8'($urandom);
		endcase
	endfunction

	// one request beat, with random gaps before it; valid is left high
	task automatic send_item(input logic [7:0] elapsed, input logic known, input status_t typed);
		status_t predicted;
		while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.elapsed_cycles <= elapsed;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		advance_counters(elapsed, predicted);
		pending_status.push_back(known ? typed : predicted);
		@(negedge clk);
	endtask

	// register write once every pending result has come back
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		req_ch.valid <= 1'b0;
		while (pending_status.size() != 0) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			dtr_pkg::CFG_TIMER_MODE:   shadow_ctrl   = value[2:0];
			dtr_pkg::CFG_RELOAD_VALUE: shadow_reload = value;
			dtr_pkg::CFG_DOUBLE_SPEED: shadow_ds     = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= !(gaps_on && $urandom_range(0, 99) < GAP_PERCENT);
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin : check_results
		status_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_status.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: div %0d timer %0d",
					rsp_ch.divider_out, rsp_ch.timer_out));
			end else begin
				want = pending_status.pop_front();
				if (rsp_ch.divider_out !== want.divider)
					report_mismatch($sformatf("divider_out got %0d want %0d",
						rsp_ch.divider_out, want.divider));
				if (rsp_ch.timer_out !== want.timer)
					report_mismatch($sformatf("timer_out got %0d want %0d",
						rsp_ch.timer_out, want.timer));
				if (rsp_ch.timer_irq !== want.irq)
					report_mismatch($sformatf("timer_irq got %0b want %0b",
						rsp_ch.timer_irq, want.irq));
				if (rsp_ch.second_tick !== want.tick)
					report_mismatch($sformatf("second_tick got %0b want %0b",
						rsp_ch.second_tick, want.tick));
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int unsigned row;
		int unsigned ph;
		int unsigned k;
		logic [2:0]  ctrl;
		req_ch.valid          = 1'b0;
		req_ch.elapsed_cycles = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = dtr_pkg::CFG_TIMER_MODE;
		cfg_ch.data           = '0;
		arst_n                = 1'b0;
		shadow_ctrl   = '0;
		shadow_reload = '0;
		shadow_ds     = 1'b0;
		div_res       = '0;
		div_val       = '0;
		tmr_res       = '0;
		tmr_val       = '0;
		tmr_sel       = '0;
		sel_held      = 1'b0;
		rtc_count     = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (row = 0; row < NUM_DIRECTED; row++) begin
			if (DIRECTED[row].kind == ROW_WRITE)
				write_reg(DIRECTED[row].reg_idx, DIRECTED[row].value);
			else
				send_item(DIRECTED[row].value, DIRECTED[row].known, DIRECTED[row].want);
		end

		// random phases, settings changed between them
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(dtr_pkg::CFG_TIMER_MODE, 8'(TMR_ON | SEL_256));
					write_reg(dtr_pkg::CFG_RELOAD_VALUE, 8'd255);
					write_reg(dtr_pkg::CFG_DOUBLE_SPEED, 8'd1);
				end
				1: begin
					write_reg(dtr_pkg::CFG_TIMER_MODE, 8'(SEL_1024));
					write_reg(dtr_pkg::CFG_RELOAD_VALUE, 8'd0);
					write_reg(dtr_pkg::CFG_DOUBLE_SPEED, 8'd0);
				end
				2: begin
					write_reg(dtr_pkg::CFG_TIMER_MODE, 8'(TMR_ON | SEL_16));
					write_reg(dtr_pkg::CFG_RELOAD_VALUE, 8'd255);
				end
				3: begin
					write_reg(dtr_pkg::CFG_TIMER_MODE, 8'(TMR_ON | SEL_64));
					write_reg(dtr_pkg::CFG_DOUBLE_SPEED, 8'd1);
				end
				default: begin
					if ($urandom_range(0, 1)) begin
						ctrl = 3'($urandom_range(0, 7));
						if ($urandom_range(0, 3) != 0)
							ctrl = ctrl | TMR_ON;
						write_reg(dtr_pkg::CFG_TIMER_MODE, (8'($urandom) & 8'hF8) | 8'(ctrl));
					end
					if ($urandom_range(0, 1))
						write_reg(dtr_pkg::CFG_RELOAD_VALUE, ($urandom_range(0, 3) == 0) ?
							8'd255 : 8'($urandom));
					if ($urandom_range(0, 1))
						write_reg(dtr_pkg::CFG_DOUBLE_SPEED, 8'($urandom));
					if ($urandom_range(0, 9) == 0)
						write_reg(CFG_NONE, 8'($urandom));
				end
			endcase
			for (k = 0; k < PHASE_ITEMS; k++)
				send_item(pick_elapsed(), 1'b0, ZERO_STATUS);
		end

		// long run of mostly full-size steps with no idling
		gaps_on = 1'b0;
		write_reg(dtr_pkg::CFG_TIMER_MODE, 8'(TMR_ON | SEL_1024));
		write_reg(dtr_pkg::CFG_DOUBLE_SPEED, 8'd0);
		for (k = 0; k < LONG_ITEMS; k++)
			send_item(($urandom_range(0, 3) == 0) ? 8'($urandom_range(200, 255)) : 8'd255,
				1'b0, ZERO_STATUS);

		// drain and settle
		req_ch.valid <= 1'b0;
		while (pending_status.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_status.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_status.size()));
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
